// File: design/rse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants of the rank sort engine.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int BEAT_WIDTH     = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } rse_state_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

endpackage

// File: design/rse_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_cell
// One sorting cell: holds one value, inserts in order, shifts toward the head.
// ----------------------------------------------------------------------------
module rse_cell
  import rse_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic signed [W-1:0] ins_value,
  input  logic                prev_take,
  input  logic signed [W-1:0] prev_value,
  input  logic                prev_valid,
  input  logic signed [W-1:0] next_value,
  input  logic                next_valid,
  output logic signed [W-1:0] value,
  output logic                valid,
  output logic                take
);

  assign take = !valid || (ins_value < value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.drain) begin
      valid <= next_valid;
    end else if (ctrl.ins && take) begin
      valid <= prev_take ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      value <= next_value;
    end else if (ctrl.ins && take) begin
      value <= prev_take ? prev_value : ins_value;
    end
  end

endmodule

// File: design/rse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_ctrl
// Batch sequencer: counts loaded beats, flags drops, paces the drain.
// ----------------------------------------------------------------------------
module rse_ctrl
  import rse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic       m_tlast,
  output logic       m_tuser,
  output cell_ctrl_t ctrl
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  rse_state_t       state;
  rse_state_t       state_next;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             in_beat;
  logic             out_beat;
  logic             full;

  assign full     = (count == CNT_W'(MAX_ITEMS));
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_beat && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_beat && m_tlast) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_LOAD:  s_tready = 1'b1;
      ST_DRAIN: m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
    m_tlast    = (count == CNT_W'(1));
    m_tuser    = dropped;
    ctrl.ins   = in_beat && !full;
    ctrl.drain = out_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.ins) begin
        count <= count + CNT_W'(1);
      end else if (out_beat) begin
        count <= count - CNT_W'(1);
      end
      if (in_beat && full) begin
        dropped <= 1'b1;
      end else if (out_beat && m_tlast) begin
        dropped <= 1'b0;
      end
    end
  end

endmodule

// File: design/rank_sort_engine_unit.sv
`timescale 1ns / 1ps
// Latency: first sorted beat is offered on m_tvalid the cycle after the last input beat.
// Throughput: one input beat per cycle while loading, one output beat per
//   cycle while draining and m_tready is high.
// The insertion chain of cells sets this pace; input is held off while draining.
// Reset (rst, synchronous) empties the chain and clears count and drop flag.
// ----------------------------------------------------------------------------
// rank_sort_engine_unit
// Stable ascending sort of one batch through a systolic insertion chain.
// ----------------------------------------------------------------------------
module rank_sort_engine_unit
  import rse_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BEAT_WIDTH-1:0] s_tdata,   // [31:0] value
  input  logic                  s_tlast,   // last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BEAT_WIDTH-1:0] m_tdata,   // [31:0] sorted_value
  output logic                  m_tlast,   // last_res
  output logic                  m_tuser    // [0] overflow
);

  localparam int EFF_WIDTH = (DATA_WIDTH < BEAT_WIDTH) ? DATA_WIDTH : BEAT_WIDTH;

  cell_ctrl_t                   ctrl;
  logic signed [EFF_WIDTH-1:0]  ins_value;
  logic signed [EFF_WIDTH-1:0]  cell_value [MAX_ITEMS];
  logic                         cell_valid [MAX_ITEMS];
  logic                         cell_take  [MAX_ITEMS];

  assign ins_value = s_tdata[EFF_WIDTH-1:0];

  rse_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .ctrl     (ctrl)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                        p_take;
    logic signed [EFF_WIDTH-1:0] p_value;
    logic                        p_valid;
    logic signed [EFF_WIDTH-1:0] n_value;
    logic                        n_valid;

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_value = '0;
      assign p_valid = 1'b0;
    end else begin : g_body
      assign p_take  = cell_take[i-1];
      assign p_value = cell_value[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_value = '0;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_value = cell_value[i+1];
      assign n_valid = cell_valid[i+1];
    end

    rse_cell #(
      .W (EFF_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .ins_value  (ins_value),
      .prev_take  (p_take),
      .prev_value (p_value),
      .prev_valid (p_valid),
      .next_value (n_value),
      .next_valid (n_valid),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .take       (cell_take[i])
    );
  end

  assign m_tdata = BEAT_WIDTH'(cell_value[0]);

endmodule

// File: tb/sv/rank_sort_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_sort_engine_unit_tb
// Self-checking bench for the rank sort engine. Batches of signed values are
// streamed in with random bursts and gaps while the output side stalls on a
// pattern of its own. Every accepted input beat feeds a batch model that
// ranks the batch on its last beat and queues the sorted beats, which are
// then compared field by field with the output stream.
// ----------------------------------------------------------------------------
module rank_sort_engine_unit_tb;
  import rse_pkg::*;

  localparam int CAP       = MAX_ITEMS_DEF;
  localparam int RAND_GOAL = 140;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        hold;
  } input_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        ovf;
  } sorted_beat_t;

  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_STALL,
    RDY_RANDOM
  } rdy_mode_t;

  typedef enum logic [1:0] {
    VAL_FULL,
    VAL_NEAR_ZERO,
    VAL_EXTREME
  } val_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BEAT_WIDTH-1:0] s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BEAT_WIDTH-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  input_beat_t  pend_q[$];
  sorted_beat_t sorted_exp_q[$];
  logic [31:0]  batch_vals[$];
  logic         batch_dropped = 1'b0;
  int           err_cnt = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           rdy_left = 0;
  rdy_mode_t    rdy_mode = RDY_OPEN;

  rank_sort_engine_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic add_beat(input logic [31:0] value, input logic last, input logic hold);
    input_beat_t b;
    b.value = value;
    b.last  = last;
    b.hold  = hold;
    pend_q.push_back(b);
  endtask

  function automatic logic [31:0] pick_value(input val_mode_t mode);
    logic [31:0] v;
    case (mode)
      VAL_NEAR_ZERO: v = 32'($signed($urandom_range(0, 8)) - 4);
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_batch(input int len, input logic hold);
    val_mode_t mode;
    mode = val_mode_t'($urandom_range(0, 2));
    for (int i = 0; i < len; i++) begin
      add_beat(pick_value(mode), i == len - 1, hold && i == 0);
    end
  endtask

  // Store the value, or drop it when full; on the last beat rank the batch.
  task automatic take_value(input logic [31:0] value, input logic last);
    logic [31:0]  ranked[CAP];
    sorted_beat_t sb;
    int           n;
    int           rank;
    if (batch_vals.size() < CAP) batch_vals.push_back(value);
    else batch_dropped = 1'b1;
    if (last) begin
      n = batch_vals.size();
      for (int i = 0; i < n; i++) begin
        rank = 0;
        for (int j = 0; j < n; j++) begin
          if ($signed(batch_vals[j]) < $signed(batch_vals[i]) ||
              (batch_vals[j] == batch_vals[i] && j < i)) rank++;
        end
        ranked[rank] = batch_vals[i];
      end
      for (int i = 0; i < n; i++) begin
        sb.value = ranked[i];
        sb.last  = (i == n - 1);
        sb.ovf   = batch_dropped;
        sorted_exp_q.push_back(sb);
      end
      batch_vals.delete();
      batch_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin : drive_proc
    input_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pend_q.size() == 0 ||
                   (pend_q[0].hold && (sorted_exp_q.size() != 0 || s_tvalid))) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.value;
        s_tlast  <= nxt.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk) begin : ready_proc
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = rdy_mode_t'($urandom_range(0, 2));
        rdy_left = $urandom_range(1, 20);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        RDY_OPEN:  m_tready <= 1'b1;
        RDY_STALL: m_tready <= 1'b0;
        default:   m_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin : check_proc
    sorted_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) take_value(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (sorted_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected beat: value=%h last=%b ovf=%b", m_tdata, m_tlast, m_tuser);
        end else begin
          want = sorted_exp_q.pop_front();
          if (m_tdata !== want.value || m_tlast !== want.last || m_tuser !== want.ovf) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("beat mismatch: exp value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                       want.value, want.last, want.ovf, m_tdata, m_tlast, m_tuser);
          end
        end
      end
    end
  end

  initial begin
    int rand_items;
    int len;
    // single-beat batches at both extremes
    add_beat(32'h8000_0000, 1'b1, 1'b0);
    add_beat(32'h7fff_ffff, 1'b1, 1'b1);
    // extremes with duplicates
    add_beat(32'h7fff_ffff, 1'b0, 1'b0);
    add_beat(32'h8000_0000, 1'b0, 1'b0);
    add_beat(32'h0000_0000, 1'b0, 1'b0);
    add_beat(32'hffff_ffff, 1'b0, 1'b0);
    add_beat(32'h0000_0001, 1'b0, 1'b0);
    add_beat(32'h0000_0000, 1'b0, 1'b0);
    add_beat(32'h8000_0000, 1'b0, 1'b0);
    add_beat(32'h7fff_ffff, 1'b1, 1'b0);
    // descending run
    for (int i = 5; i >= 1; i--) add_beat(32'(i), i == 1, 1'b0);
    // all equal
    for (int i = 0; i < 4; i++) add_beat(32'hffff_fffd, i == 3, 1'b0);
    add_beat(32'h0000_0001, 1'b0, 1'b0);
    add_beat(32'h8000_0001, 1'b1, 1'b0);

    // overflow batch: the last beat itself lands beyond capacity
    len = $urandom_range(CAP + 1, CAP + 4);
    add_batch(len, 1'b1);
    rand_items = len;
    // exactly full, no overflow
    add_batch(CAP, 1'b1);
    rand_items += CAP;
    while (rand_items < RAND_GOAL) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_batch(len, $urandom_range(0, 7) == 0);
      rand_items += len;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || s_tvalid || sorted_exp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
design/rse_pkg.sv
design/rse_cell.sv
design/rse_ctrl.sv
design/rank_sort_engine_unit.sv
tb/sv/rank_sort_engine_unit_tb.sv
